// File: hw/rtl/bbc_pkg.sv
// Shared constants, codes and types for the block buffer cache tag engine.
`default_nettype none

package bbc_pkg;

  localparam int NUM_BUFFERS = 16;
  localparam int IDX_W       = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int FREE_W      = $clog2(NUM_BUFFERS + 1);

  localparam int OP_W      = 2;
  localparam int DEV_W     = 8;
  localparam int SECTOR_W  = 32;
  localparam int SLOT_W    = 4;
  localparam int STATUS_W  = 3;
  localparam int BUF_W     = 4;
  localparam int REQ_W     = 2;
  localparam int FREEO_W   = 5;
  localparam int CNT_W     = 32;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 80;

  typedef enum logic [OP_W-1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_DONE    = 2'd3
  } bbc_op_t;

  localparam logic [STATUS_W-1:0] STS_HIT     = 3'd0;
  localparam logic [STATUS_W-1:0] STS_MISS    = 3'd1;
  localparam logic [STATUS_W-1:0] STS_BUSY    = 3'd2;
  localparam logic [STATUS_W-1:0] STS_NOBUF   = 3'd3;
  localparam logic [STATUS_W-1:0] STS_DONE    = 3'd4;
  localparam logic [STATUS_W-1:0] STS_NOTHELD = 3'd5;

  localparam logic [REQ_W-1:0] REQ_NONE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_HIT_SCAN,
    S_VIC_SCAN,
    S_REL_SCAN,
    S_EMIT
  } bbc_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/block_buffer_cache_tags_core.sv
// Tag and recency engine of a fully associative disk-block buffer cache.
//
// Usage: one request word enters on the in_ stream (read block, write held
// buffer, release buffer, disk transfer done) and exactly one result word
// leaves on the out_ stream, carrying status, buffer index, disk request and
// the free, access and hit counters after the request.
// A single tag comparator walks the recency list one entry per cycle under a
// small sequencer; the block takes one request at a time and in_tready is
// low while it works.
// Sequence after acceptance: a write, disk done or misuse is decoded and its
// result goes to the output; a release first searches the recency list for
// its buffer; a read does a tag scan from most recent, then a victim scan
// from least recent on a miss.
// Reset clears all marks and counters, sets free_buffers to NUM_BUFFERS and
// orders the recency list from buffer NUM_BUFFERS-1 down to 0.
// If the receiver stalls, the finished result holds in the output register;
// a next request may be taken, but its result waits until that one is delivered.
`default_nettype none

module block_buffer_cache_tags_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // op[1:0], dev[9:2], sector[41:10], slot[45:42], zero fill
  input  wire logic [bbc_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // status[2:0], buffer[6:3], disk_request[8:7], free_buffers[13:9],
  // access_count[45:14], hit_count[77:46], zero fill
  output logic [bbc_pkg::OUT_DATA_W-1:0]       out_tdata
);
  import bbc_pkg::*;

  bbc_state_t state_r, state_nxt;

  // captured request
  bbc_op_t             op_r;
  logic [DEV_W-1:0]    dev_r;
  logic [SECTOR_W-1:0] sector_r;
  logic [SLOT_W-1:0]   slot_r;

  // per-buffer storage
  logic [DEV_W-1:0]    dev_mem_r [NUM_BUFFERS];
  logic [DEV_W-1:0]    dev_mem_nxt [NUM_BUFFERS];
  logic [SECTOR_W-1:0] sec_mem_r [NUM_BUFFERS];
  logic [SECTOR_W-1:0] sec_mem_nxt [NUM_BUFFERS];
  logic [IDX_W-1:0]    rec_r [NUM_BUFFERS];
  logic [IDX_W-1:0]    rec_nxt [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] in_use_r, in_use_nxt;
  logic [NUM_BUFFERS-1:0] held_r, held_nxt;
  logic [NUM_BUFFERS-1:0] valid_r, valid_nxt;
  logic [NUM_BUFFERS-1:0] dirty_r, dirty_nxt;

  logic [FREE_W-1:0]   free_r, free_nxt;
  logic [CNT_W-1:0]    access_r, access_nxt;
  logic [CNT_W-1:0]    miss_r, miss_nxt;

  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [IDX_W-1:0]    res_buf_r, res_buf_nxt;
  logic [REQ_W-1:0]    res_req_r, res_req_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [IDX_W-1:0]    cur_b;
  logic [IDX_W-1:0]    slot_idx;
  logic                slot_ok;
  logic                tag_hit;
  logic                cnt_last;
  logic                cnt_first;
  logic                in_fire;
  logic                emit_go;
  logic [CNT_W-1:0]    hit_cnt;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign cur_b     = rec_r[cnt_r];
  assign slot_idx  = IDX_W'(slot_r);
  assign slot_ok   = (int'(slot_r) < NUM_BUFFERS) && held_r[slot_idx];
  // the shared tag comparator
  assign tag_hit   = in_use_r[cur_b] && (dev_mem_r[cur_b] == dev_r)
                     && (sec_mem_r[cur_b] == sector_r);
  assign cnt_last  = (cnt_r == IDX_W'(NUM_BUFFERS - 1));
  assign cnt_first = (cnt_r == '0);
  assign emit_go   = !out_valid_r || out_tready;
  assign hit_cnt   = access_r - miss_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (op_r == OP_READ) state_nxt = S_HIT_SCAN;
        else if (op_r == OP_RELEASE && slot_ok) state_nxt = S_REL_SCAN;
        else state_nxt = S_EMIT;
      end
      S_HIT_SCAN: begin
        if (tag_hit) state_nxt = S_EMIT;
        else if (cnt_last) state_nxt = S_VIC_SCAN;
      end
      S_VIC_SCAN: begin
        if ((!held_r[cur_b] && !dirty_r[cur_b]) || cnt_first) state_nxt = S_EMIT;
      end
      S_REL_SCAN: begin
        if (cur_b == slot_idx) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    dev_mem_nxt    = dev_mem_r;
    sec_mem_nxt    = sec_mem_r;
    rec_nxt        = rec_r;
    in_use_nxt     = in_use_r;
    held_nxt       = held_r;
    valid_nxt      = valid_r;
    dirty_nxt      = dirty_r;
    free_nxt       = free_r;
    access_nxt     = access_r;
    miss_nxt       = miss_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_buf_nxt    = res_buf_r;
    res_req_nxt    = res_req_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
      end
      S_DECODE: begin
        cnt_nxt        = '0;
        res_status_nxt = STS_DONE;
        res_buf_nxt    = slot_idx;
        res_req_nxt    = REQ_NONE;
        if (op_r != OP_READ) begin
          if (!slot_ok) begin
            res_status_nxt = STS_NOTHELD;
          end else begin
            case (op_r)
              OP_WRITE: begin
                dirty_nxt[slot_idx] = 1'b1;
                res_req_nxt         = REQ_WRITE;
              end
              OP_DONE: begin
                valid_nxt[slot_idx] = 1'b1;
                dirty_nxt[slot_idx] = 1'b0;
              end
              default: ;
            endcase
          end
        end
      end
      S_HIT_SCAN: begin
        if (tag_hit) begin
          res_buf_nxt = cur_b;
          res_req_nxt = REQ_NONE;
          if (held_r[cur_b]) begin
            res_status_nxt = STS_BUSY;
          end else begin
            held_nxt[cur_b] = 1'b1;
            free_nxt        = free_r - FREE_W'(1);
            access_nxt      = access_r + CNT_W'(1);
            if (valid_r[cur_b]) begin
              res_status_nxt = STS_HIT;
            end else begin
              miss_nxt       = miss_r + CNT_W'(1);
              res_status_nxt = STS_MISS;
              res_req_nxt    = REQ_READ;
            end
          end
        end else if (!cnt_last) begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      S_VIC_SCAN: begin
        if (!held_r[cur_b] && !dirty_r[cur_b]) begin
          // recycle the least recent free, clean buffer
          dev_mem_nxt[cur_b] = dev_r;
          sec_mem_nxt[cur_b] = sector_r;
          in_use_nxt[cur_b]  = 1'b1;
          held_nxt[cur_b]    = 1'b1;
          valid_nxt[cur_b]   = 1'b0;
          dirty_nxt[cur_b]   = 1'b0;
          free_nxt           = free_r - FREE_W'(1);
          access_nxt         = access_r + CNT_W'(1);
          miss_nxt           = miss_r + CNT_W'(1);
          res_status_nxt     = STS_MISS;
          res_buf_nxt        = cur_b;
          res_req_nxt        = REQ_READ;
        end else if (cnt_first) begin
          res_status_nxt = STS_NOBUF;
          res_buf_nxt    = '0;
          res_req_nxt    = REQ_NONE;
        end else begin
          cnt_nxt = cnt_r - IDX_W'(1);
        end
      end
      S_REL_SCAN: begin
        if (cur_b == slot_idx) begin
          // shift the entries ahead of it back one place, put it in front
          for (int i = 1; i < NUM_BUFFERS; i++) begin
            if (IDX_W'(i) <= cnt_r) rec_nxt[i] = rec_r[i-1];
          end
          rec_nxt[0]         = slot_idx;
          held_nxt[slot_idx] = 1'b0;
          free_nxt           = free_r + FREE_W'(1);
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, hit_cnt, access_r, FREEO_W'(free_r),
                           res_req_r, BUF_W'(res_buf_r), res_status_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_use_r    <= '0;
      held_r      <= '0;
      valid_r     <= '0;
      dirty_r     <= '0;
      free_r      <= FREE_W'(NUM_BUFFERS);
      access_r    <= '0;
      miss_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        rec_r[i] <= IDX_W'(NUM_BUFFERS - 1 - i);
      end
    end else begin
      state_r     <= state_nxt;
      in_use_r    <= in_use_nxt;
      held_r      <= held_nxt;
      valid_r     <= valid_nxt;
      dirty_r     <= dirty_nxt;
      free_r      <= free_nxt;
      access_r    <= access_nxt;
      miss_r      <= miss_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      rec_r       <= rec_nxt;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    dev_mem_r    <= dev_mem_nxt;
    sec_mem_r    <= sec_mem_nxt;
    res_status_r <= res_status_nxt;
    res_buf_r    <= res_buf_nxt;
    res_req_r    <= res_req_nxt;
    out_data_r   <= out_data_nxt;
    if (in_fire) begin
      op_r     <= bbc_op_t'(in_tdata[1:0]);
      dev_r    <= in_tdata[9:2];
      sector_r <= in_tdata[41:10];
      slot_r   <= in_tdata[45:42];
    end
  end

endmodule

`default_nettype wire
